// ===== rtl/fdnbr_pkg.sv =====
// fdnbr_pkg: shared types, constants and the coefficient table for the
// FIR / DPLL / NRZI bit recovery core. No dependencies.
package fdnbr_pkg;

    localparam int STEP_W     = 15;
    localparam int STEP_RESET = 13107;
    localparam int PHASE_W    = 16;
    localparam int PROTO_TAPS = 81;
    localparam int PROTO_HALF = 40;

    // Q2.14 raised-cosine taps 0..40; tap k > 40 mirrors to 80 - k
    localparam int RC_HALF [PROTO_HALF + 1] = '{
        -321, -32, 287, 617, 939, 1232, 1474, 1645, 1727, 1708,
        1577, 1333, 979, 525, -9, -601, -1219, -1830, -2396, -2876,
        -3233, -3429, -3433, -3219, -2769, -2073, -1133, 39, 1420, 2979,
        4674, 6456, 8269, 10056, 11756, 13313, 14670, 15780, 16603, 17109,
        17280
    };

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last_tap;
        logic out_free;
    } t_sts;

    // coefficient of tap k rescaled to cw - 2 fraction bits, round half up
    function automatic int coef_at(input int k, input int cw);
        int c;
        int dn;
        int up;
        int half;
        int idx;
        if (k >= PROTO_TAPS) begin
            return 0;
        end
        idx  = (k <= PROTO_HALF) ? k : (PROTO_TAPS - 1 - k);
        c    = RC_HALF[idx];
        dn   = (cw < 16) ? (16 - cw) : 0;
        up   = (cw > 16) ? (cw - 16) : 0;
        half = (dn > 0) ? (1 <<< (dn - 1)) : 0;
        return ((c + half) >>> dn) <<< up;
    endfunction

endpackage

// ===== rtl/fir_dpll_nrzi_bit_recovery_core.sv =====
// fir_dpll_nrzi_bit_recovery_core: top level, stream ports and config port.
// Depends on fdnbr_pkg, fdnbr_ctrl and fdnbr_datapath.
//
// Takes one audio sample word, filters the TAPS samples before it with a
// symmetric raised-cosine FIR, tracks bit timing with a 16-bit phase
// accumulator nudged on every sign change, and on each phase wrap emits one
// NRZI-decoded bit (1 when the slice matches the previous one). For each
// sample one multiply-accumulate walks the taps out of the delay-line
// memory, one per cycle, then the read, multiply and add registers drain
// and the phase is updated. The output register lets the next sample start
// while a bit waits; the update cycle holds only if a bit is still unclaimed.
// The delay line reads as zero until written, so no clearing pass follows
// reset.
// phase_step may be written only while the core is idle.
module fir_dpll_nrzi_bit_recovery_core
    import fdnbr_pkg::*;
#(
    parameter int TAPS         = 81,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16,
    parameter int NUDGE_SHIFT  = 4,
    localparam int S_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // [0] decoded_bit
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [STEP_W-1:0]    i_cfg_data        // phase_step
);

    t_cmd cmd;
    t_sts sts;
    logic out_bit;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {7'b0, out_bit};

    fdnbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    fdnbr_datapath #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .NUDGE_SHIFT  (NUDGE_SHIFT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_bit   (out_bit)
    );

endmodule

// ===== rtl/fdnbr_ctrl.sv =====
// fdnbr_ctrl: sequencer for one sample: tap walk, pipeline drain, update.
// Depends on fdnbr_pkg.
module fdnbr_ctrl
    import fdnbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: n_state = ST_DRAIN_B;
            ST_DRAIN_B: n_state = ST_FINISH;
            ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/fdnbr_datapath.sv =====
// fdnbr_datapath: delay-line memory, shared MAC, phase accumulator, NRZI
// slicer and output register. Depends on fdnbr_pkg.
module fdnbr_datapath
    import fdnbr_pkg::*;
#(
    parameter int TAPS         = 81,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16,
    parameter int NUDGE_SHIFT  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_sts                           o_sts,
    input  logic                           i_cfg_valid,
    input  logic [STEP_W-1:0]              i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_out_bit
);

    localparam int ADDR_W = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    logic signed [SAMPLE_WIDTH-1:0] r_mem [TAPS];

    logic [STEP_W-1:0]              r_step;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic [ADDR_W-1:0]              r_wr_addr;
    logic [ADDR_W-1:0]              r_rd_addr;
    logic [ADDR_W-1:0]              r_tap;
    logic [FILL_W-1:0]              r_fill;
    logic signed [SAMPLE_WIDTH-1:0] r_rd_data;
    logic                           r_rd_ok;
    logic signed [COEF_WIDTH-1:0]   r_coef;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_v1;
    logic                           r_v2;
    logic signed [ACC_W-1:0]        r_acc;
    logic [PHASE_W-1:0]             r_phase;
    logic                           r_prev_sign;
    logic                           r_prev_slice;
    logic                           r_out_valid;
    logic                           r_out_bit;

    logic                           curr;
    logic                           emit;
    logic [PHASE_W+1:0]             n_phase;
    logic [PHASE_W+1:0]             nudge;
    logic signed [SAMPLE_WIDTH-1:0] mul_a;

    assign o_sts.last_tap = (r_tap == ADDR_W'(TAPS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_bit      = r_out_bit;

    assign curr  = !r_acc[ACC_W-1] && (r_acc != '0);
    assign nudge = (PHASE_W + 2)'(r_step >> NUDGE_SHIFT);
    assign mul_a = r_rd_ok ? r_rd_data : '0;

    always_comb begin
        n_phase = {2'b00, r_phase};
        if (curr != r_prev_sign) begin
            if (r_phase[PHASE_W-1]) begin
                n_phase = n_phase - nudge;
            end else begin
                n_phase = n_phase + nudge;
            end
        end
        n_phase = n_phase + (PHASE_W + 2)'(r_step);
        emit    = |n_phase[PHASE_W+1:PHASE_W];
    end

    // delay line
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_mem[r_wr_addr] <= r_sample;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // MAC pipeline payload, sample latch and decoded bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sample <= i_sample;
        end
        r_rd_ok <= (FILL_W'(r_rd_addr) < r_fill);
        r_coef  <= COEF_WIDTH'(coef_at(int'(r_tap), COEF_WIDTH));
        r_prod  <= mul_a * r_coef;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.finish && emit) begin
            r_out_bit <= (curr == r_prev_slice);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_W'(STEP_RESET);
            r_wr_addr    <= '0;
            r_rd_addr    <= '0;
            r_tap        <= '0;
            r_fill       <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_phase      <= '0;
            r_prev_sign  <= 1'b0;
            r_prev_slice <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_rd_addr <= r_wr_addr;
                r_tap     <= '0;
            end else if (i_cmd.issue) begin
                r_rd_addr <= (r_rd_addr == ADDR_W'(TAPS - 1)) ? '0 : r_rd_addr + 1'b1;
                r_tap     <= r_tap + 1'b1;
            end
            if (i_cmd.finish && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_wr_addr   <= (r_wr_addr == ADDR_W'(TAPS - 1)) ? '0 : r_wr_addr + 1'b1;
                if (r_fill != FILL_W'(TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_prev_sign <= curr;
                r_phase     <= n_phase[PHASE_W-1:0];
                if (emit) begin
                    r_prev_slice <= curr;
                end
            end
        end
    end

endmodule

// ===== bench/fir_dpll_nrzi_bit_recovery_core_tb.sv =====
// Testbench for fir_dpll_nrzi_bit_recovery_core: drives audio sample words,
// rebuilds the FIR / phase-tracking / NRZI chain locally and checks every bit.
// Depends on fdnbr_pkg and the core RTL.
module fir_dpll_nrzi_bit_recovery_core_tb;
    import fdnbr_pkg::*;

    localparam int NTAPS      = 81;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 120;

    typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE, CHK_ZERO} t_chk;

    typedef struct {
        logic [15:0] smp;
        t_chk        chk;
    } t_row;

    // Q2.14 raised-cosine pulse, taps 0..40, mirrored above the center
    localparam int PULSE_TAPS [41] = '{
        -321, -32, 287, 617, 939, 1232, 1474, 1645, 1727, 1708,
        1577, 1333, 979, 525, -9, -601, -1219, -1830, -2396, -2876,
        -3233, -3429, -3433, -3219, -2769, -2073, -1133, 39, 1420, 2979,
        4674, 6456, 8269, 10056, 11756, 13313, 14670, 15780, 16603, 17109,
        17280
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [15:0]       i_s_axis_tdata = '0;   // [15:0] sample
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [7:0]        o_m_axis_tdata;        // [0] decoded_bit
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [STEP_W-1:0] i_cfg_data = '0;       // phase_step

    // local copy of the core state
    longint            hist [NTAPS];
    int                hist_pos;
    bit                last_sign;
    bit                last_slice;
    logic [17:0]       phase_acc;
    logic [STEP_W-1:0] step_now;

    bit                bits_due [$];
    int                mismatches = 0;
    int                fed = 0;
    int                idle_cycles = 0;
    bit                steady = 1'b0;
    t_row              steer_rows [24];

    fir_dpll_nrzi_bit_recovery_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int tap_weight(input int k);
        return (k <= 40) ? PULSE_TAPS[k] : PULSE_TAPS[NTAPS - 1 - k];
    endfunction

    function automatic logic [15:0] clip16(input int v);
        if (v > 32767) begin
            return 16'h7FFF;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // filter the history, track the bit phase, slice and NRZI-decode on wrap
    task automatic recover_bit(input logic signed [15:0] smp, output bit emit,
                               output bit value);
        longint      sum;
        int          p;
        bit          sgn;
        logic [17:0] nudge;
        sum = 0;
        p = hist_pos;
        value = 1'b0;
        for (int k = 0; k < NTAPS; k++) begin
            sum += hist[p] * longint'(tap_weight(k));
            p = (p + 1 == NTAPS) ? 0 : p + 1;
        end
        hist[hist_pos] = longint'(smp);
        hist_pos = (hist_pos + 1 == NTAPS) ? 0 : hist_pos + 1;
        sgn = (sum > 0);
        nudge = 18'(step_now >> 4);
        if (sgn != last_sign) begin
            phase_acc = (phase_acc < 18'h08000) ? phase_acc + nudge : phase_acc - nudge;
        end
        last_sign = sgn;
        phase_acc = phase_acc + 18'(step_now);
        emit = (phase_acc > 18'h0FFFF);
        if (emit) begin
            value = (sgn == last_slice);
            last_slice = sgn;
            phase_acc[17:16] = 2'b00;
        end
    endtask

    task automatic feed_sample(input logic [15:0] smp, input t_chk chk);
        bit emit;
        bit value;
        while (!steady && $urandom_range(0, 99) < 24) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!o_s_axis_tready);
        fed++;
        recover_bit(smp, emit, value);
        case (chk)
            CHK_MODEL: begin
                if (emit) begin
                    bits_due.push_back(value);
                end
            end
            CHK_ONE:  bits_due.push_back(1'b1);
            CHK_ZERO: bits_due.push_back(1'b0);
            default: ;
        endcase
    endtask

    // core must be idle: no bit owed, and past the latency of a silent sample
    task automatic load_step(input logic [STEP_W-1:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (bits_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        step_now = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [STEP_W-1:0] step, input int count, input bit calm);
        int goal;
        int spb;
        int pol;
        int lvl;
        int nbits;
        int mode;
        load_step(step);
        steady <= calm;
        goal = fed + count;
        spb = (step == 0) ? 8 : 65536 / int'(step);
        if (spb > 64) begin
            spb = 64;
        end
        if (spb < 1) begin
            spb = 1;
        end
        pol = 1;
        while (fed < goal) begin
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                nbits = $urandom_range(4, 24);
                lvl = $urandom_range(1500, 30000);
                for (int b = 0; b < nbits && fed < goal; b++) begin
                    if ($urandom_range(0, 1)) begin
                        pol = -pol;
                    end
                    for (int j = 0; j < spb && fed < goal; j++) begin
                        feed_sample(clip16(pol * lvl + int'($urandom_range(0, 2047)) - 1024),
                                    CHK_MODEL);
                    end
                end
            end else if (mode == 7) begin
                repeat ($urandom_range(1, 8)) feed_sample(16'($urandom), CHK_MODEL);
            end else if (mode == 8) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: feed_sample(16'h7FFF, CHK_MODEL);
                        1: feed_sample(16'h8000, CHK_MODEL);
                        2: feed_sample(16'hFFFF, CHK_MODEL);
                        default: feed_sample(16'h0000, CHK_MODEL);
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 10)) feed_sample(16'h0000, CHK_MODEL);
            end
        end
    endtask

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (bits_due.size() == 0) begin
                    $error("unexpected word: decoded_bit actual %0b", o_m_axis_tdata[0]);
                    mismatches++;
                end else begin
                    want = bits_due.pop_front();
                    if (o_m_axis_tdata[0] !== want) begin
                        $error("decoded_bit mismatch: expected %0b actual %0b",
                               want, o_m_axis_tdata[0]);
                        mismatches++;
                    end
                end
            end
            i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("fir_dpll_nrzi_bit_recovery_core test failed");
                $finish;
            end
        end
    end

    initial begin
        for (int k = 0; k < NTAPS; k++) begin
            hist[k] = 0;
        end
        hist_pos   = 0;
        last_sign  = 1'b0;
        last_slice = 1'b0;
        phase_acc  = '0;
        step_now   = STEP_W'(STEP_RESET);

        // silence after reset: fifth wrap-free sample, sixth wraps with equal slices
        for (int r = 0; r < 5; r++) begin
            steer_rows[r] = '{16'h0000, CHK_NONE};
        end
        steer_rows[5]  = '{16'h0000, CHK_ONE};
        steer_rows[6]  = '{16'h7FFF, CHK_MODEL};
        steer_rows[7]  = '{16'h8000, CHK_MODEL};
        steer_rows[8]  = '{16'hFFFF, CHK_MODEL};
        steer_rows[9]  = '{16'h0001, CHK_MODEL};
        steer_rows[10] = '{16'h5555, CHK_MODEL};
        steer_rows[11] = '{16'hAAAA, CHK_MODEL};
        for (int r = 12; r < 18; r++) begin
            steer_rows[r] = '{16'h5DC0, CHK_MODEL};
        end
        for (int r = 18; r < 24; r++) begin
            steer_rows[r] = '{16'hA240, CHK_MODEL};
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steer_rows[r]) begin
            feed_sample(steer_rows[r].smp, steer_rows[r].chk);
        end

        // zero step freezes the phase; step 1 barely moves it
        run_phase(15'd0,     30,  1'b0);
        run_phase(15'd1,     30,  1'b0);
        run_phase(15'd32767, 200, 1'b0);
        run_phase(15'd2048,  200, 1'b0);
        run_phase(15'd6554,  220, 1'b1);
        run_phase(15'd8192,  200, 1'b0);
        run_phase(15'd4681,  220, 1'b0);
        run_phase(15'd16384, 200, 1'b0);
        run_phase(15'd13107, 250, 1'b0);

        i_s_axis_tvalid <= 1'b0;
        while (bits_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && bits_due.size() == 0) begin
            $display("fir_dpll_nrzi_bit_recovery_core test passed");
        end else begin
            $display("fir_dpll_nrzi_bit_recovery_core test failed");
        end
        $finish;
    end

endmodule
